@@ sv/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// tli_pkg: shared types, widths and ROM contents for the table interpolator
// Breakpoint and table values are held in units of 1e-5 and converted to
// fixed point at elaboration time by to_fix().
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  // field and datapath widths
  localparam int KEY_W  = 32;            // input key, unsigned fixed point
  localparam int OUT_W  = 32;            // result value
  localparam int FIX_W  = 40;            // breakpoints at the widest fraction
  localparam int VAL_W  = 34;            // table values at the widest fraction
  localparam int PM_W   = KEY_W + VAL_W; // product magnitude
  localparam int Q_W    = VAL_W;         // quotient bits, |q| <= |r1 - r0|

  localparam int unsigned E5_SCALE = 100000;

  localparam int ALT_LEN  = 14;
  localparam int MACH_LEN = 17;

  // curve select codes
  typedef enum logic [1:0] {
    OP_DENS  = 2'd0,
    OP_SOUND = 2'd1,
    OP_GRAV  = 2'd2,
    OP_DRAG  = 2'd3
  } op_e;

  // per-word control carried down the pipeline
  typedef struct packed {
    logic             above;   // key beyond the last breakpoint
    logic             direct;  // exact hit or first entry: base is the answer
    logic             nz;      // segment has nonzero width
    logic             neg;     // slope is negative
    logic [VAL_W-1:0] base;    // r0, or r1 when direct
  } meta_t;

  localparam logic [31:0] ALT_E5 [ALT_LEN] = '{
    32'd0, 32'd100000000, 32'd200000000, 32'd300000000, 32'd400000000,
    32'd500000000, 32'd600000000, 32'd700000000, 32'd800000000, 32'd900000000,
    32'd1000000000, 32'd1500000000, 32'd2000000000, 32'd2500000000};

  localparam logic [31:0] DENS_E5 [ALT_LEN] = '{
    32'd122500, 32'd111200, 32'd100700, 32'd90930, 32'd81940, 32'd73640,
    32'd66010, 32'd59000, 32'd52580, 32'd46710, 32'd41350, 32'd19480,
    32'd8891, 32'd4008};

  localparam logic [31:0] SND_E5 [ALT_LEN] = '{
    32'd34000000, 32'd33600000, 32'd33200000, 32'd32800000, 32'd32400000,
    32'd32000000, 32'd31600000, 32'd31200000, 32'd30800000, 32'd30300000,
    32'd29900000, 32'd29500000, 32'd29500000, 32'd29500000};

  localparam logic [31:0] GRAV_E5 [ALT_LEN] = '{
    32'd980700, 32'd980400, 32'd980100, 32'd979700, 32'd979400, 32'd979100,
    32'd978800, 32'd978500, 32'd978200, 32'd977900, 32'd977600, 32'd976100,
    32'd974500, 32'd973000};

  localparam logic [31:0] MACH_E5 [MACH_LEN] = '{
    32'd0, 32'd30000, 32'd50000, 32'd70000, 32'd89000, 32'd92000, 32'd96000,
    32'd98000, 32'd100000, 32'd102000, 32'd106000, 32'd124000, 32'd153000,
    32'd199000, 32'd287000, 32'd289000, 32'd500000};

  localparam logic [31:0] DRAG_E5 [MACH_LEN] = '{
    32'd16290, 32'd16290, 32'd16590, 32'd20310, 32'd25970, 32'd30100,
    32'd32870, 32'd40020, 32'd42580, 32'd43350, 32'd44830, 32'd40640,
    32'd36630, 32'd28970, 32'd22970, 32'd23060, 32'd26560};

  // 1e-5 units to fixed point, rounded to nearest (ties up)
  function automatic logic [FIX_W-1:0] to_fix(input logic [31:0] e5,
                                              input int unsigned frac);
    logic [63:0] scaled;
    scaled = ({32'd0, e5} << frac) + 64'(E5_SCALE / 2);
    return FIX_W'(scaled / 64'(E5_SCALE));
  endfunction

endpackage

`default_nettype wire

@@ sv/table_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise-linear lookup over constant curves
// Input channel (in_valid_i/in_ready_o) carries op_i and key_i; op_i picks
// air density, speed of sound or gravity by altitude, or drag by Mach.
// Output channel (out_valid_o/out_ready_i) returns one word per input word:
// value_o, and above_range_o set with value_o zero when the key lies past the
// last breakpoint. Exact breakpoint hits return the table entry; otherwise
// the segment is interpolated with the quotient truncated toward zero and the
// sum clamped to the 32-bit range.
// Throughput: one word per cycle while the skid register below is empty. Stages from
// input acceptance to output valid: compare, fetch, multiply, 34 divider stages,
// final sum; the one-bit-per-stage divider makes up most of them.
// Reset clears all valid bits; the data registers are not reset.
// A stalled receiver is absorbed by a one-word skid register: the pipeline
// freezes only while that register is full, and in_ready_o is the registered
// complement of its registered full flag.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_ENTRIES = 17
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] key_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o,
  output logic             above_range_o
);
  import tli_pkg::*;

  localparam int SUM_W = VAL_W + 2;

  logic en;

  // search and fetch
  logic             s2_valid;
  meta_t            s2_meta;
  logic [KEY_W-1:0] s2_kd;
  logic [VAL_W-1:0] s2_mag;
  logic [FIX_W-1:0] s2_den;

  tli_search #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .op_i    (op_i),
    .key_i   (key_i),
    .valid_o (s2_valid),
    .meta_o  (s2_meta),
    .kd_o    (s2_kd),
    .mag_o   (s2_mag),
    .den_o   (s2_den)
  );

  // slope product
  logic             s3_valid;
  meta_t            s3_meta;
  logic [PM_W-1:0]  s3_prod;
  logic [FIX_W-1:0] s3_den;

  tli_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid),
    .meta_i  (s2_meta),
    .kd_i    (s2_kd),
    .mag_i   (s2_mag),
    .den_i   (s2_den),
    .valid_o (s3_valid),
    .meta_o  (s3_meta),
    .prod_o  (s3_prod),
    .den_o   (s3_den)
  );

  // divide by segment width
  logic           dv_valid;
  meta_t          dv_meta;
  logic [Q_W-1:0] dv_quo;

  tli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid),
    .meta_i  (s3_meta),
    .prod_i  (s3_prod),
    .den_i   (s3_den),
    .valid_o (dv_valid),
    .meta_o  (dv_meta),
    .quo_o   (dv_quo)
  );

  // final sum and clamp
  logic [SUM_W-1:0] term, sum;
  logic [31:0]      value_d;

  always_comb begin
    term = (dv_meta.direct | ~dv_meta.nz) ? '0 : SUM_W'(dv_quo);
    sum  = dv_meta.neg ? SUM_W'(dv_meta.base) - term : SUM_W'(dv_meta.base) + term;
    if (dv_meta.above || sum[SUM_W-1]) begin
      value_d = '0;
    end else if (|sum[SUM_W-2:OUT_W]) begin
      value_d = '1;
    end else begin
      value_d = sum[OUT_W-1:0];
    end
  end

  logic        fin_valid_q;
  logic [31:0] fin_value_q;
  logic        fin_above_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fin_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_value_q <= value_d;
      fin_above_q <= dv_meta.above;
    end
  end

  // skid register: holds a word the receiver did not take
  logic        skid_valid_q, skid_valid_d;
  logic [31:0] skid_value_q;
  logic        skid_above_q;

  always_comb begin
    if (skid_valid_q) begin
      skid_valid_d = ~out_ready_i;
    end else begin
      skid_valid_d = fin_valid_q & ~out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      skid_value_q <= fin_value_q;
      skid_above_q <= fin_above_q;
    end
  end

  // pipeline advances while the skid register is empty
  assign en            = ~skid_valid_q;
  assign in_ready_o    = en;
  assign out_valid_o   = skid_valid_q | fin_valid_q;
  assign value_o       = skid_valid_q ? skid_value_q : fin_value_q;
  assign above_range_o = skid_valid_q ? skid_above_q : fin_above_q;

endmodule

`default_nettype wire

@@ sv/tli_search.sv @@
// ----------------------------------------------------------------------------
// tli_search: breakpoint search and segment fetch
// Stage 1 compares the key against every breakpoint of the chosen curve.
// Stage 2 picks the first breakpoint at or above the key and fetches the
// segment ends, the key offset, the segment width and the slope magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_search #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_ENTRIES = 17
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [1:0]                 op_i,
  input  wire logic [tli_pkg::KEY_W-1:0]  key_i,
  output logic                            valid_o,
  output tli_pkg::meta_t                  meta_o,
  output logic [tli_pkg::KEY_W-1:0]       kd_o,
  output logic [tli_pkg::VAL_W-1:0]       mag_o,
  output logic [tli_pkg::FIX_W-1:0]       den_o
);
  import tli_pkg::*;

  localparam int N_ALT  = (MAX_ENTRIES < ALT_LEN) ? MAX_ENTRIES : ALT_LEN;
  localparam int N_MAX  = (MAX_ENTRIES < MACH_LEN) ? MAX_ENTRIES : MACH_LEN;
  localparam int IDX_W  = (N_MAX > 1) ? $clog2(N_MAX) : 1;

  // constant ROMs in fixed point
  logic [FIX_W-1:0] alt_bp  [N_MAX];
  logic [FIX_W-1:0] mach_bp [N_MAX];
  logic [VAL_W-1:0] dens_v  [N_MAX];
  logic [VAL_W-1:0] snd_v   [N_MAX];
  logic [VAL_W-1:0] grav_v  [N_MAX];
  logic [VAL_W-1:0] drag_v  [N_MAX];

  for (genvar g = 0; g < N_MAX; g++) begin : g_rom
    localparam int AI = (g < ALT_LEN) ? g : 0;
    assign alt_bp[g]  = to_fix(ALT_E5[AI], FRAC_BITS);
    assign mach_bp[g] = to_fix(MACH_E5[g], FRAC_BITS);
    assign dens_v[g]  = VAL_W'(to_fix(DENS_E5[AI], FRAC_BITS));
    assign snd_v[g]   = VAL_W'(to_fix(SND_E5[AI], FRAC_BITS));
    assign grav_v[g]  = VAL_W'(to_fix(GRAV_E5[AI], FRAC_BITS));
    assign drag_v[g]  = VAL_W'(to_fix(DRAG_E5[g], FRAC_BITS));
  end

  // ---- stage 1: parallel compares ----
  logic [N_MAX-1:0] ge_d, eq_d;
  logic [N_MAX-1:0] ge_q, eq_q;
  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [KEY_W-1:0] s1_key_q;

  always_comb begin
    logic             is_drag;
    logic [FIX_W-1:0] bp;
    logic [FIX_W-1:0] key_ext;
    is_drag = (op_e'(op_i) == OP_DRAG);
    key_ext = FIX_W'(key_i);
    for (int g = 0; g < N_MAX; g++) begin
      bp      = is_drag ? mach_bp[g] : alt_bp[g];
      ge_d[g] = (is_drag || (g < N_ALT)) && (bp >= key_ext);
      eq_d[g] = (is_drag || (g < N_ALT)) && (bp == key_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ge_q     <= ge_d;
      eq_q     <= eq_d;
      s1_op_q  <= op_e'(op_i);
      s1_key_q <= key_i;
    end
  end

  // ---- stage 2: first hit, segment fetch ----
  logic [IDX_W-1:0] idx, idx_lo;
  logic             found;
  logic [FIX_W-1:0] d0, d1;
  logic [VAL_W-1:0] r0, r1;
  logic [VAL_W:0]   dr;
  meta_t            meta_d;
  logic [KEY_W-1:0] kd_d;
  logic [VAL_W-1:0] mag_d;
  logic [FIX_W-1:0] den_d;

  // lowest set compare bit
  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int g = N_MAX - 1; g >= 0; g--) begin
      if (ge_q[g]) begin
        idx   = IDX_W'(g);
        found = 1'b1;
      end
    end
  end

  assign idx_lo = (idx == '0) ? '0 : idx - 1'b1;

  always_comb begin
    if (s1_op_q == OP_DRAG) begin
      d0 = mach_bp[idx_lo];
      d1 = mach_bp[idx];
    end else begin
      d0 = alt_bp[idx_lo];
      d1 = alt_bp[idx];
    end
    case (s1_op_q)
      OP_DENS:  begin r0 = dens_v[idx_lo]; r1 = dens_v[idx]; end
      OP_SOUND: begin r0 = snd_v[idx_lo];  r1 = snd_v[idx];  end
      OP_GRAV:  begin r0 = grav_v[idx_lo]; r1 = grav_v[idx]; end
      OP_DRAG:  begin r0 = drag_v[idx_lo]; r1 = drag_v[idx]; end
      default:  begin r0 = '0;             r1 = '0;          end
    endcase
  end

  always_comb begin
    dr            = {1'b0, r1} - {1'b0, r0};
    meta_d.above  = ~found;
    meta_d.direct = eq_q[idx] | (idx == '0);
    meta_d.nz     = (d1 != d0);
    meta_d.neg    = dr[VAL_W];
    meta_d.base   = meta_d.direct ? r1 : r0;
    // key sits above d0 on an interpolated segment, so the offset fits the key
    kd_d          = s1_key_q - d0[KEY_W-1:0];
    mag_d         = dr[VAL_W] ? VAL_W'(-dr) : dr[VAL_W-1:0];
    den_d         = d1 - d0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_o <= meta_d;
      kd_o   <= kd_d;
      mag_o  <= mag_d;
      den_o  <= den_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/tli_mul.sv @@
// ----------------------------------------------------------------------------
// tli_mul: slope product stage
// Multiplies the key offset by the slope magnitude, one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_mul (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire tli_pkg::meta_t            meta_i,
  input  wire logic [tli_pkg::KEY_W-1:0] kd_i,
  input  wire logic [tli_pkg::VAL_W-1:0] mag_i,
  input  wire logic [tli_pkg::FIX_W-1:0] den_i,
  output logic                           valid_o,
  output tli_pkg::meta_t                 meta_o,
  output logic [tli_pkg::PM_W-1:0]       prod_o,
  output logic [tli_pkg::FIX_W-1:0]      den_o
);
  import tli_pkg::*;

  logic [PM_W-1:0] prod_d;

  assign prod_d = PM_W'(kd_i) * PM_W'(mag_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_o <= meta_i;
      prod_o <= prod_d;
      den_o  <= den_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/tli_div.sv @@
// ----------------------------------------------------------------------------
// tli_div: pipelined restoring divider
// One quotient bit per stage. The product is below den * 2^Q_W, so the
// partial remainder starts from the product's upper bits and Q_W stages
// finish the unsigned quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire tli_pkg::meta_t            meta_i,
  input  wire logic [tli_pkg::PM_W-1:0]  prod_i,
  input  wire logic [tli_pkg::FIX_W-1:0] den_i,
  output logic                           valid_o,
  output tli_pkg::meta_t                 meta_o,
  output logic [tli_pkg::Q_W-1:0]        quo_o
);
  import tli_pkg::*;

  // stage registers, entry k holds the state after k+1 quotient bits
  logic             vld_q  [Q_W];
  meta_t            meta_q [Q_W];
  logic [FIX_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]   low_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  logic [FIX_W-1:0] dvs_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             vld_in;
    meta_t            meta_in;
    logic [FIX_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [FIX_W-1:0] dvs_in;
    logic [FIX_W:0]   trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign meta_in = meta_i;
      assign rem_in  = FIX_W'(prod_i[PM_W-1:Q_W]);
      assign low_in  = prod_i[Q_W-1:0];
      assign quo_in  = '0;
      assign dvs_in  = den_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign meta_in = meta_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign dvs_in  = dvs_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, low_in[Q_W-1]};
    assign fits  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_q[k] <= meta_in;
        rem_q[k]  <= fits ? FIX_W'(trial - {1'b0, dvs_in}) : trial[FIX_W-1:0];
        low_q[k]  <= {low_in[Q_W-2:0], 1'b0};
        quo_q[k]  <= {quo_in[Q_W-2:0], fits};
        dvs_q[k]  <= dvs_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign meta_o  = meta_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];

endmodule

`default_nettype wire

@@ tb/table_linear_interpolator_tb.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator_tb: self-checking bench for the curve interpolator
// Drives a table of directed lookups (curve ends, exact breakpoints, flat and
// interpolated segments, keys past the last breakpoint), then random keys over
// all four curves. Every returned word is checked against a local model of
// the breakpoint ROMs. Both sides idle at random; the output also holds off
// for a long stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator_tb;
  import tli_pkg::*;

  localparam int FRAC        = 16;
  localparam int ENTRY_LIMIT = 17;
  localparam int RAND_WORDS  = 850;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 50;
  localparam int CYCLE_LIMIT = 300000;

  // curve points in units of 1e-5
  localparam int unsigned ALT_PTS [14] = '{
    0, 100000000, 200000000, 300000000, 400000000, 500000000, 600000000,
    700000000, 800000000, 900000000, 1000000000, 1500000000, 2000000000,
    2500000000};
  localparam int unsigned DENS_PTS [14] = '{
    122500, 111200, 100700, 90930, 81940, 73640, 66010, 59000, 52580,
    46710, 41350, 19480, 8891, 4008};
  localparam int unsigned SND_PTS [14] = '{
    34000000, 33600000, 33200000, 32800000, 32400000, 32000000, 31600000,
    31200000, 30800000, 30300000, 29900000, 29500000, 29500000, 29500000};
  localparam int unsigned GRAV_PTS [14] = '{
    980700, 980400, 980100, 979700, 979400, 979100, 978800, 978500,
    978200, 977900, 977600, 976100, 974500, 973000};
  localparam int unsigned MACH_PTS [17] = '{
    0, 30000, 50000, 70000, 89000, 92000, 96000, 98000, 100000,
    102000, 106000, 124000, 153000, 199000, 287000, 289000, 500000};
  localparam int unsigned DRAG_PTS [17] = '{
    16290, 16290, 16590, 20310, 25970, 30100, 32870, 40020, 42580,
    43350, 44830, 40640, 36630, 28970, 22970, 23060, 26560};

  typedef struct packed {
    logic [31:0] value;
    logic        above;
  } lookup_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic        typed;   // expected word given in the row
    logic [31:0] value;
    logic        above;
  } dir_row_t;

  logic        clk;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  op_drv = 2'd0;
  logic [31:0] key_drv = 32'd0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [31:0] value;
  wire         above_range;

  lookup_t  pending_lookups [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       words_checked = 0;
  int       above_seen = 0;
  int       cycles = 0;
  int       press_left = 0;
  bit       hold_req = 1'b0;
  bit       calm_send = 1'b0;
  bit       calm_recv = 1'b0;

  table_linear_interpolator #(
    .FRAC_BITS  (FRAC),
    .MAX_ENTRIES(ENTRY_LIMIT)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op_drv),
    .key_i        (key_drv),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .value_o      (value),
    .above_range_o(above_range)
  );

  // 1e-5 units to fixed point, nearest with ties up
  function automatic longint e5_to_q(input int unsigned e5);
    return ((longint'(e5) << FRAC) + 64'd50000) / 64'd100000;
  endfunction

  function automatic int curve_len(input op_e op);
    int n;
    n = (op == OP_DRAG) ? 17 : 14;
    return (n > ENTRY_LIMIT) ? ENTRY_LIMIT : n;
  endfunction

  function automatic longint curve_x(input op_e op, input int i);
    return e5_to_q((op == OP_DRAG) ? MACH_PTS[i] : ALT_PTS[i]);
  endfunction

  function automatic longint curve_y(input op_e op, input int i);
    case (op)
      OP_DENS:  return e5_to_q(DENS_PTS[i]);
      OP_SOUND: return e5_to_q(SND_PTS[i]);
      OP_GRAV:  return e5_to_q(GRAV_PTS[i]);
      default:  return e5_to_q(DRAG_PTS[i]);
    endcase
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v < 0) return 32'd0;
    if (v > 64'sh0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // expected word for one lookup
  function automatic lookup_t interp_lookup(input op_e op, input logic [31:0] key);
    longint  k, d0, d1, r0, r1, q;
    lookup_t res;
    k = longint'({32'd0, key});
    for (int i = 0; i < curve_len(op); i++) begin
      d1 = curve_x(op, i);
      r1 = curve_y(op, i);
      if (d1 == k) begin
        res = '{value: clamp32(r1), above: 1'b0};
        return res;
      end
      if (d1 > k) begin
        if (i == 0) begin
          res = '{value: clamp32(r1), above: 1'b0};
          return res;
        end
        d0 = curve_x(op, i - 1);
        r0 = curve_y(op, i - 1);
        q  = (d1 != d0) ? ((k - d0) * (r1 - r0)) / (d1 - d0) : 64'sd0;
        res = '{value: clamp32(r0 + q), above: 1'b0};
        return res;
      end
    end
    res = '{value: 32'd0, above: 1'b1};
    return res;
  endfunction

  // random key: mostly inside the curve, some near breakpoints, some anywhere
  function automatic logic [31:0] pick_key(input op_e op);
    longint top;
    int     n;
    n   = curve_len(op);
    top = curve_x(op, n - 1);
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1, 2:    return 32'(curve_x(op, $urandom_range(0, n - 1)) + $urandom_range(0, 6) - 3);
      default: return $urandom_range(0, 32'(top + top / 16));
    endcase
  endfunction

  function automatic int send_gap();
    if (press_left > 0) begin
      press_left--;
      return 0;
    end
    return calm_send ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH word %0d: %s expected %h got %h", words_checked, what, want, got);
    errors++;
  endtask

  task automatic add_row(input op_e op, input logic [31:0] key, input logic typed,
                         input logic [31:0] val, input logic above);
    dir_row_t r;
    r = '{op: op, key: key, typed: typed, value: val, above: above};
    dir_rows.push_back(r);
  endtask

  // offer one input word and log its expected result on acceptance
  task automatic offer_word(input op_e op, input logic [31:0] key, input lookup_t want,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_drv   <= op;
    key_drv  <= key;
    do @(posedge clk); while (!in_ready);
    pending_lookups.push_back(want);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset, once
  initial begin
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles,
               pending_lookups.size());
      $display("table_linear_interpolator test failed");
      $finish;
    end
  end

  // output side: random stalls, calm stretches, one long hold-off
  initial begin
    int stall;
    int recv_count;
    recv_count = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      if (recv_count % 64 == 0) calm_recv = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = calm_recv ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      recv_count++;
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("word with nothing pending", 32'd0, value);
      end else begin
        want = pending_lookups.pop_front();
        if (value !== want.value) report_mismatch("value", want.value, value);
        if (above_range !== want.above)
          report_mismatch("above_range", 32'(want.above), 32'(above_range));
      end
      if (above_range === 1'b1) above_seen++;
      words_checked++;
    end
  end

  // stimulus
  initial begin
    lookup_t want;
    op_e     op;
    dir_row_t r;

    // curve ends, exact hits, flat and sloped segments, past the end
    add_row(OP_DENS,  32'h0000_0000,          1'b0, 32'd0, 1'b0);
    add_row(OP_DENS,  32'hFFFF_FFFF,          1'b1, 32'd0, 1'b1);
    add_row(OP_DENS,  {16'd1000, 16'h0000},   1'b0, 32'd0, 1'b0);
    add_row(OP_DENS,  {16'd12345, 16'h8000},  1'b0, 32'd0, 1'b0);
    add_row(OP_DENS,  {16'd25000, 16'h0000},  1'b0, 32'd0, 1'b0);
    add_row(OP_DENS,  {16'd25000, 16'h0001},  1'b1, 32'd0, 1'b1);
    add_row(OP_SOUND, 32'h0000_0000,          1'b0, 32'd0, 1'b0);
    add_row(OP_SOUND, {16'd22000, 16'h1234},  1'b0, 32'd0, 1'b0);
    add_row(OP_SOUND, {16'd15000, 16'h0000},  1'b0, 32'd0, 1'b0);
    add_row(OP_SOUND, 32'hFFFF_FFFF,          1'b1, 32'd0, 1'b1);
    add_row(OP_GRAV,  32'h0000_0000,          1'b0, 32'd0, 1'b0);
    add_row(OP_GRAV,  {16'd500, 16'h0000},    1'b0, 32'd0, 1'b0);
    add_row(OP_GRAV,  {16'd24999, 16'hFFFF},  1'b0, 32'd0, 1'b0);
    add_row(OP_GRAV,  32'hFFFF_FFFF,          1'b1, 32'd0, 1'b1);
    add_row(OP_DRAG,  32'h0000_0000,          1'b0, 32'd0, 1'b0);
    add_row(OP_DRAG,  {16'd0, 16'h3000},      1'b0, 32'd0, 1'b0);
    add_row(OP_DRAG,  {16'd0, 16'hF333},      1'b0, 32'd0, 1'b0);
    add_row(OP_DRAG,  {16'd1, 16'h0000},      1'b0, 32'd0, 1'b0);
    add_row(OP_DRAG,  {16'd3, 16'h8000},      1'b0, 32'd0, 1'b0);
    add_row(OP_DRAG,  {16'd5, 16'h0000},      1'b0, 32'd0, 1'b0);
    add_row(OP_DRAG,  {16'd5, 16'h0001},      1'b1, 32'd0, 1'b1);
    add_row(OP_DRAG,  32'hFFFF_FFFF,          1'b1, 32'd0, 1'b1);

    wait (rst_ni === 1'b1);
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      want = r.typed ? lookup_t'({r.value, r.above}) : interp_lookup(op_e'(r.op), r.key);
      offer_word(op_e'(r.op), r.key, want, send_gap());
    end

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 64 == 0) calm_send = ($urandom_range(0, 3) == 0);
      // long output hold-off while the input keeps pushing
      if (i == 300) begin
        hold_req   = 1'b1;
        press_left = 120;
      end
      // let the pipeline drain completely once
      if (i == 600) begin
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
      end
      op = op_e'($urandom_range(0, 3));
      key_pick: begin
        logic [31:0] k;
        k = pick_key(op);
        offer_word(op, k, interp_lookup(op, k), send_gap());
      end
    end
    in_valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d words (%0d past the last breakpoint) over all four curves,",
             words_checked, above_seen);
    $display("including a %0d-cycle output stall and a full pipeline drain", HOLD_CYCLES);
    if (errors == 0) begin
      $display("table_linear_interpolator test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("table_linear_interpolator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
